// ===== rtl/core/pwe_pkg.sv =====
// Shared types and constants for the payload wrench estimator.
`timescale 1ns / 1ps
package pwe_pkg;
  localparam int unsigned NumParams = 10;
  localparam int unsigned NumRows   = 6;
  localparam int unsigned NumRegs   = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_M_MCX   = 3'd0,
    REG_MCY_MCZ = 3'd1,
    REG_IXX_IXY = 3'd2,
    REG_IXZ_IYY = 3'd3,
    REG_IYZ_IZZ = 3'd4
  } cfg_idx_e;

  // One row of the regressor entries, each already saturated to 32 bits.
  typedef logic signed [31:0] entry_t;
  typedef entry_t [NumParams-1:0] row_t;
  typedef row_t [NumRows-1:0] regr_t;
  typedef logic signed [31:0] param_t;
  typedef param_t [NumParams-1:0] params_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== rtl/core/pwe_regressor.sv =====
// Front stages: negation, velocity products and regressor entries.
`timescale 1ns / 1ps
module pwe_regressor #(
  parameter int unsigned FracBits = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [11:0][31:0]  in_i,
  output pwe_pkg::regr_t            regr_o
);
  logic signed [11:0][32:0] n_q;
  logic signed [5:0][65:0]  pr;
  logic signed [5:0][63:0]  p_q;
  logic signed [2:0][33:0]  d_q;
  logic signed [2:0][32:0]  e_q;
  logic signed [63:0] wx2, wy2, wz2, wxy, wxz, wyz;
  logic signed [63:0] ex, ey, ez, dx, dy, dz;
  logic signed [5:0][9:0][63:0] r;
  pwe_pkg::regr_t regr_q;

  // stage 1: negate and register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 12; i++) n_q[i] <= -{{1{in_i[i][31]}}, in_i[i]};
    end
  end

  // packed elements read back unsigned, so sign is restored explicitly
  assign pr[0] = $signed(n_q[0]) * $signed(n_q[0]);
  assign pr[1] = $signed(n_q[1]) * $signed(n_q[1]);
  assign pr[2] = $signed(n_q[2]) * $signed(n_q[2]);
  assign pr[3] = $signed(n_q[0]) * $signed(n_q[1]);
  assign pr[4] = $signed(n_q[0]) * $signed(n_q[2]);
  assign pr[5] = $signed(n_q[1]) * $signed(n_q[2]);

  // stage 2: products of velocities, Q-shifted with floor; also linear accel minus gravity, and angular accel
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) p_q[i] <= 64'($signed(pr[i]) >>> FracBits);
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= 34'($signed(n_q[3+i])) - 34'($signed(n_q[9+i]));
        e_q[i] <= n_q[6+i];
      end
    end
  end

  assign {wx2, wy2, wz2} = {p_q[0], p_q[1], p_q[2]};
  assign {wxy, wxz, wyz} = {p_q[3], p_q[4], p_q[5]};
  assign ex = 64'($signed(e_q[0]));
  assign ey = 64'($signed(e_q[1]));
  assign ez = 64'($signed(e_q[2]));
  assign dx = 64'($signed(d_q[0]));
  assign dy = 64'($signed(d_q[1]));
  assign dz = 64'($signed(d_q[2]));

  always_comb begin
    r = '0;
    r[0][0] = dx; r[0][1] = -wy2 - wz2; r[0][2] = wxy - ez; r[0][3] = wxz + ey;
    r[1][0] = dy; r[1][1] = wxy + ez; r[1][2] = -wx2 - wz2; r[1][3] = wyz - ex;
    r[2][0] = dz; r[2][1] = wxz - ey; r[2][2] = wyz + ex; r[2][3] = -wx2 - wy2;
    r[3][2] = dz; r[3][3] = -dy; r[3][4] = ex; r[3][5] = ey - wxz;
    r[3][6] = ez + wxy; r[3][7] = -wyz; r[3][8] = wy2 - wz2; r[3][9] = wyz;
    r[4][1] = -dz; r[4][3] = dx; r[4][4] = wxz; r[4][5] = ex + wyz;
    r[4][6] = wz2 - wx2; r[4][7] = ey; r[4][8] = ez - wxy; r[4][9] = -wxz;
    r[5][1] = dy; r[5][2] = -dx; r[5][4] = -wxy; r[5][5] = wx2 - wy2;
    r[5][6] = ex - wyz; r[5][7] = wxy; r[5][8] = ey + wxz; r[5][9] = ez;
  end

  // stage 3: saturated entries
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < pwe_pkg::NumRows; k++)
        for (int i = 0; i < pwe_pkg::NumParams; i++)
          regr_q[k][i] <= pwe_pkg::sat32(r[k][i]);
    end
  end
  assign regr_o = regr_q;
endmodule

// ===== rtl/core/pwe_cell.sv =====
// One multiply-accumulate cell of the chain: adds its parameter's term to each row.
`timescale 1ns / 1ps
module pwe_cell #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned AccW     = 64
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [31:0]                     param_i,
  input  logic signed [pwe_pkg::NumRows-1:0][31:0] entry_i,
  input  logic signed [pwe_pkg::NumRows-1:0][AccW-1:0] acc_i,
  output logic signed [pwe_pkg::NumRows-1:0][AccW-1:0] acc_o
);
  logic signed [pwe_pkg::NumRows-1:0][63:0]     prod;
  logic signed [pwe_pkg::NumRows-1:0][AccW-1:0] acc_q;

  always_comb begin
    for (int k = 0; k < pwe_pkg::NumRows; k++) prod[k] = $signed(entry_i[k]) * param_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < pwe_pkg::NumRows; k++)
        acc_q[k] <= acc_i[k] + AccW'($signed(prod[k]) >>> FracBits);
    end
  end
  assign acc_o = acc_q;
endmodule

// ===== rtl/core/payload_wrench_estimator_core.sv =====
// Top level: config registers, regressor front end, MAC cell chain, output control.
// An input transfer passes the regressor stages and then the MAC cell chain before its result is valid.
// Throughput: one sample per cycle; the pipeline advances whenever the output can move.
// The chain of ten MAC cells, one per payload parameter, together with the regressor stages sets the depth.
// Reset clears the parameter registers to zero and all valid flags.
`timescale 1ns / 1ps
module payload_wrench_estimator_core #(
  parameter int unsigned FracBits = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic signed [31:0] ang_vel_x_i, ang_vel_y_i, ang_vel_z_i,
  input  logic signed [31:0] lin_acc_x_i, lin_acc_y_i, lin_acc_z_i,
  input  logic signed [31:0] ang_acc_x_i, ang_acc_y_i, ang_acc_z_i,
  input  logic signed [31:0] grav_x_i, grav_y_i, grav_z_i,
  input  logic cfg_we_i,
  input  logic [pwe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pwe_pkg::CfgDataW-1:0] cfg_data_i,
  output logic valid_o,
  input  logic ready_i,
  output logic signed [31:0] est_force_x_o, est_force_y_o, est_force_z_o,
  output logic signed [31:0] est_torque_x_o, est_torque_y_o, est_torque_z_o
);
  localparam int unsigned NP = pwe_pkg::NumParams;
  localparam int unsigned NR = pwe_pkg::NumRows;
  localparam int unsigned AccW = 64;
  localparam int unsigned Depth = 3 + NP;

  logic [pwe_pkg::NumRegs-1:0][63:0] reg_q;
  pwe_pkg::params_t phi;
  logic [Depth-1:0] vld_q;
  logic en;
  logic signed [11:0][31:0] in_vec;
  pwe_pkg::regr_t regr;
  logic signed [NP:0][NR-1:0][AccW-1:0] acc;
  // entries ride along the chain, delayed one cell per stage
  logic signed [NP-2:0][NR-1:0][NP-1:0][31:0] ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwe_pkg::REG_M_MCX:   reg_q[0] <= cfg_data_i;
        pwe_pkg::REG_MCY_MCZ: reg_q[1] <= cfg_data_i;
        pwe_pkg::REG_IXX_IXY: reg_q[2] <= cfg_data_i;
        pwe_pkg::REG_IXZ_IYY: reg_q[3] <= cfg_data_i;
        pwe_pkg::REG_IYZ_IZZ: reg_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < pwe_pkg::NumRegs; i++) begin
      phi[2*i]   = reg_q[i][31:0];
      phi[2*i+1] = reg_q[i][63:32];
    end
  end

  // whole pipe moves together; holds only when the final result is stalled
  assign en      = !(valid_o && !ready_i);
  assign ready_o = en;
  assign valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  assign in_vec = {grav_z_i, grav_y_i, grav_x_i, ang_acc_z_i, ang_acc_y_i, ang_acc_x_i,
                   lin_acc_z_i, lin_acc_y_i, lin_acc_x_i,
                   ang_vel_z_i, ang_vel_y_i, ang_vel_x_i};

  pwe_regressor #(.FracBits(FracBits)) u_regr (
    .clk_i(clk_i), .en_i(en), .in_i(in_vec), .regr_o(regr)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NR; k++) ent_q[0][k] <= regr[k];
      for (int c = 1; c < NP - 1; c++) ent_q[c] <= ent_q[c-1];
    end
  end

  assign acc[0] = '0;
  for (genvar c = 0; c < NP; c++) begin : g_cell
    logic signed [NR-1:0][31:0] ent;
    if (c == 0) begin : g_head
      always_comb begin
        for (int k = 0; k < NR; k++) ent[k] = regr[k][c];
      end
    end else begin : g_tail
      always_comb begin
        for (int k = 0; k < NR; k++) ent[k] = ent_q[c-1][k][c];
      end
    end
    pwe_cell #(.FracBits(FracBits), .AccW(AccW)) u_cell (
      .clk_i(clk_i), .en_i(en), .param_i(phi[c]), .entry_i(ent),
      .acc_i(acc[c]), .acc_o(acc[c+1])
    );
  end

  assign est_force_x_o  = pwe_pkg::sat32(acc[NP][0]);
  assign est_force_y_o  = pwe_pkg::sat32(acc[NP][1]);
  assign est_force_z_o  = pwe_pkg::sat32(acc[NP][2]);
  assign est_torque_x_o = pwe_pkg::sat32(acc[NP][3]);
  assign est_torque_y_o = pwe_pkg::sat32(acc[NP][4]);
  assign est_torque_z_o = pwe_pkg::sat32(acc[NP][5]);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o) else $error("result dropped");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> $stable(est_force_x_o)) else $error("result moved");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o) else $error("stalled while empty output");
endmodule
